[rtl/swhfd_pkg.sv]
// shared types and constants for the single-wire humidity frame decoder
package swhfd_pkg;

    localparam int FRAME_BITS       = 40;
    localparam int PULSE_WIDTH_BITS = 16;
    localparam int CNT_W            = $clog2(FRAME_BITS + 1);
    localparam int HUM_W            = 12;
    localparam int TEMP_W           = 12;
    localparam int STATUS_W         = 3;
    localparam int CFG_ADDR_W       = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int QUEUE_DEPTH      = 2;
    localparam int S_TDATA_W        = 16;
    localparam int M_TDATA_W        = 32;

    // input item kinds carried on tuser
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_PULSE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ONE_THRESHOLD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HUM_MIN       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HUM_MAX       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEMP_MIN      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEMP_MAX      = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_TIMEOUT    = 3'd1,
        ST_CHECKSUM   = 3'd2,
        ST_TENTHS     = 3'd3,
        ST_HUM_RANGE  = 3'd4,
        ST_TEMP_RANGE = 3'd5
    } status_t;

    typedef struct packed {
        logic [PULSE_WIDTH_BITS-1:0] one_threshold_us;
        logic [HUM_W-1:0]            humidity_min_tenths;
        logic [HUM_W-1:0]            humidity_max_tenths;
        logic signed [TEMP_W-1:0]    temp_min_tenths;
        logic signed [TEMP_W-1:0]    temp_max_tenths;
    } cfg_t;

    // one classified event handed from the front to the back
    typedef struct packed {
        logic                  timeout;
        logic [FRAME_BITS-1:0] frame;
    } evt_t;

endpackage

[rtl/swhfd_front.sv]
// front part: accepts pulse items, shifts in bits and raises frame or timeout events
module swhfd_front
    import swhfd_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [PULSE_WIDTH_BITS-1:0] one_threshold_us,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [PULSE_WIDTH_BITS-1:0] high_width_us,
    input  logic                        kind,
    input  logic                        q_full,
    output logic                        push,
    output evt_t                        push_evt
);

    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  active_reg, active_next;
    logic [CNT_W-1:0]      count_inc;
    logic                  accept;
    logic                  data_bit;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign count_inc = CNT_W'(count_reg + 1'b1);
    assign data_bit  = (high_width_us > one_threshold_us);

    always_comb begin
        shift_next       = shift_reg;
        count_next       = count_reg;
        active_next      = active_reg;
        push             = 1'b0;
        push_evt.timeout = 1'b0;
        push_evt.frame   = {shift_reg[FRAME_BITS-2:0], data_bit};
        if (accept) begin
            if (kind == KIND_START) begin
                shift_next  = '0;
                count_next  = '0;
                active_next = 1'b1;
            end else if (active_reg) begin
                if (high_width_us == '0) begin
                    active_next      = 1'b0;
                    count_next       = '0;
                    push             = 1'b1;
                    push_evt.timeout = 1'b1;
                end else begin
                    shift_next = {shift_reg[FRAME_BITS-2:0], data_bit};
                    count_next = count_inc;
                    if (count_inc == CNT_W'(FRAME_BITS)) begin
                        active_next = 1'b0;
                        count_next  = '0;
                        push        = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        if (!aresetn) begin
            count_reg  <= '0;
            active_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            active_reg <= active_next;
        end
    end

endmodule

[rtl/swhfd_queue.sv]
// short event queue between the front and the back
module swhfd_queue
    import swhfd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  evt_t in_data,
    output logic full,
    output logic out_valid,
    output evt_t out_data,
    input  logic out_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    evt_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              wr_en, rd_en;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign wr_en     = in_valid && !full;
    assign rd_en     = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (wr_en && !rd_en) begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end else if (rd_en && !wr_en) begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/swhfd_back.sv]
// back part: checks a finished frame and holds the result for the output channel
module swhfd_back
    import swhfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 q_valid,
    input  evt_t                 q_data,
    output logic                 q_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [7:0]               b0, b1, b2, b3, b4;
    logic [7:0]               sum;
    logic [HUM_W-1:0]         hum;
    logic [TEMP_W-1:0]        mag;
    logic signed [TEMP_W-1:0] temp;
    status_t                  status;
    logic [HUM_W-1:0]         hum_out;
    logic signed [TEMP_W-1:0] temp_out;

    logic                     valid_reg, valid_next;
    status_t                  status_reg;
    logic [HUM_W-1:0]         hum_reg;
    logic signed [TEMP_W-1:0] temp_reg;

    assign b0 = q_data.frame[39:32];
    assign b1 = q_data.frame[31:24];
    assign b2 = q_data.frame[23:16];
    assign b3 = q_data.frame[15:8];
    assign b4 = q_data.frame[7:0];

    assign sum  = 8'(b0 + b1 + b2 + b3);
    // times ten as x8 + x2
    assign hum  = {1'b0, b0, 3'b000} + {3'b000, b0, 1'b0} + {4'b0000, b1};
    assign mag  = {2'b00, b2[6:0], 3'b000} + {4'b0000, b2[6:0], 1'b0} + {4'b0000, b3};
    assign temp = b2[7] ? $signed(TEMP_W'(-mag)) : $signed(mag);

    always_comb begin
        status   = ST_OK;
        hum_out  = hum;
        temp_out = temp;
        if (q_data.timeout) begin
            status   = ST_TIMEOUT;
            hum_out  = '0;
            temp_out = '0;
        end else if (sum != b4) begin
            status   = ST_CHECKSUM;
            hum_out  = '0;
            temp_out = '0;
        end else if (b1 > 8'd9 || b3 > 8'd9) begin
            status   = ST_TENTHS;
            hum_out  = '0;
            temp_out = '0;
        end else if (hum < cfg.humidity_min_tenths || hum > cfg.humidity_max_tenths) begin
            status = ST_HUM_RANGE;
        end else if (temp < cfg.temp_min_tenths || temp > cfg.temp_max_tenths) begin
            status = ST_TEMP_RANGE;
        end
    end

    // output register frees up when empty or being taken
    assign q_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (q_ready) begin
            valid_next = q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_ready && q_valid) begin
            status_reg <= status;
            hum_reg    <= hum_out;
            temp_reg   <= temp_out;
        end
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(M_TDATA_W - STATUS_W - HUM_W - TEMP_W)'(0),
                       temp_reg, hum_reg, status_reg};

endmodule

[rtl/single_wire_humidity_frame_decoder_core.sv]
// top level of the single-wire humidity frame decoder
//
//   channel   dir  handshake          payload
//   s_        in   s_tvalid/s_tready  tdata: high_width_us, tuser: kind
//   m_        out  m_tvalid/m_tready  tdata: status, humidity_tenths, temperature_tenths
//   cfg_      in   cfg_wr_en          cfg_addr, cfg_wdata
//
// one pulse item per cycle while s_tready is high; a finished frame or timeout is written
// into the queue and from there into the back part's output register, which drives
// m_tvalid; the result transfers when m_tready is high.
// a two-entry event queue parts the front from the back, so pulses keep flowing while
// a result waits on m_tready; s_tready drops only when the queue is full.
// aresetn is synchronous; it idles the decoder and loads the register defaults.
module single_wire_humidity_frame_decoder_core
    import swhfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] high_width_us
    input  logic                  s_tuser,   // [0] kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [2:0] status, [14:3] humidity_tenths,
                                             // [26:15] temperature_tenths
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg_reg;
    logic q_full;
    logic push;
    evt_t push_evt;
    logic q_valid;
    evt_t q_data;
    logic q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.one_threshold_us    <= PULSE_WIDTH_BITS'(40);
            cfg_reg.humidity_min_tenths <= HUM_W'(0);
            cfg_reg.humidity_max_tenths <= HUM_W'(1000);
            cfg_reg.temp_min_tenths     <= TEMP_W'(-200);
            cfg_reg.temp_max_tenths     <= TEMP_W'(600);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_ONE_THRESHOLD: cfg_reg.one_threshold_us    <= cfg_wdata;
                CFG_HUM_MIN:       cfg_reg.humidity_min_tenths <= cfg_wdata[HUM_W-1:0];
                CFG_HUM_MAX:       cfg_reg.humidity_max_tenths <= cfg_wdata[HUM_W-1:0];
                CFG_TEMP_MIN:      cfg_reg.temp_min_tenths     <= cfg_wdata[TEMP_W-1:0];
                CFG_TEMP_MAX:      cfg_reg.temp_max_tenths     <= cfg_wdata[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    swhfd_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .one_threshold_us (cfg_reg.one_threshold_us),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .high_width_us    (s_tdata[PULSE_WIDTH_BITS-1:0]),
        .kind             (s_tuser),
        .q_full           (q_full),
        .push             (push),
        .push_evt         (push_evt)
    );

    swhfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push),
        .in_data   (push_evt),
        .full      (q_full),
        .out_valid (q_valid),
        .out_data  (q_data),
        .out_ready (q_ready)
    );

    swhfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_ready  (q_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
